### design/pbl_pkg.sv
// shared types, widths and command codes for the polyline bounds and length block
// used by the channel interfaces, the top level and the checker
`default_nettype none

package pbl_pkg;

  localparam int CMD_W   = 4;
  localparam int COORD_W = 32;
  localparam int LEN_W   = 48;
  localparam int FRAC_W  = 16;
  localparam int AXES    = 3;

  // square of a coordinate difference, radicand and root widths
  localparam int SQ_W   = 2 * COORD_W;
  localparam int RAD_W  = SQ_W + 2;
  localparam int ROOT_W = RAD_W / 2;
  localparam int REM_W  = ROOT_W + 2;
  localparam int CNT_W  = $clog2(ROOT_W + 1);

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [LEN_W-1:0] len_t;

  localparam coord_t COORD_POS_MAX = coord_t'({1'b0, {(COORD_W-1){1'b1}}});
  localparam coord_t COORD_NEG_MAX = coord_t'({1'b1, {(COORD_W-1){1'b0}}});
  localparam len_t   LEN_MAX       = {LEN_W{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_POINT_DRAW = 4'd0,
    CMD_LINE_MOVE  = 4'd1,
    CMD_TRI_MOVE   = 4'd2,
    CMD_POLY_MOVE  = 4'd3,
    CMD_LINE_DRAW  = 4'd4,
    CMD_TRI_DRAW   = 4'd5,
    CMD_POLY_DRAW  = 4'd6,
    CMD_TRI_END    = 4'd7,
    CMD_POLY_END   = 4'd8,
    CMD_OTHER      = 4'd9
  } cmd_t;

endpackage

`default_nettype wire

### design/pbl_in_if.sv
// request channel carrying one drawing command with its point
// depends on pbl_pkg
`default_nettype none

interface pbl_in_if;
  logic                            valid;
  logic                            ready;
  logic [pbl_pkg::CMD_W-1:0]       command;
  logic signed [pbl_pkg::COORD_W-1:0] point_x;
  logic signed [pbl_pkg::COORD_W-1:0] point_y;
  logic signed [pbl_pkg::COORD_W-1:0] point_z;
  logic                            list_end;

  modport source (output valid, command, point_x, point_y, point_z, list_end,
                  input ready);
  modport sink (input valid, command, point_x, point_y, point_z, list_end,
                output ready);
endinterface

`default_nettype wire

### design/pbl_out_if.sv
// result channel carrying the bounds, path length and flags of one list
// depends on pbl_pkg
`default_nettype none

interface pbl_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [pbl_pkg::COORD_W-1:0] min_x;
  logic signed [pbl_pkg::COORD_W-1:0] min_y;
  logic signed [pbl_pkg::COORD_W-1:0] min_z;
  logic signed [pbl_pkg::COORD_W-1:0] max_x;
  logic signed [pbl_pkg::COORD_W-1:0] max_y;
  logic signed [pbl_pkg::COORD_W-1:0] max_z;
  logic [pbl_pkg::LEN_W-1:0]          path_length;
  logic                               bounds_empty;
  logic                               draw_without_move;

  modport source (output valid, min_x, min_y, min_z, max_x, max_y, max_z,
                  path_length, bounds_empty, draw_without_move, input ready);
  modport sink (input valid, min_x, min_y, min_z, max_x, max_y, max_z,
                path_length, bounds_empty, draw_without_move, output ready);
endinterface

`default_nettype wire

### design/polyline_bbox_and_length.sv
// sequence: a point, move or other request is taken from the idle state; a draw or end request
// stalls the input while it runs through the magnitude, 32 serial multiply steps run on all
// three axes at once, two sums, 33 root steps and the add; no new request is taken until then
// the last request of a list then goes to the emit state, which waits while the previous
// result is still held and then registers the result (after the accept or add step)
// reset: synchronous rst clears bounds, length, previous point, flags and the result valid
`default_nettype none

module polyline_bbox_and_length (
  input  logic clk,
  input  logic rst,
  pbl_in_if.sink    items,
  pbl_out_if.source results
);
  import pbl_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_ABS, S_MUL, S_SUM1, S_SUM2, S_ROOT, S_ACCUM, S_EMIT
  } state_t;

  state_t state;

  coord_t low  [AXES];
  coord_t high [AXES];
  coord_t prev [AXES];
  len_t   length_sum;
  logic   segment_open;
  logic   warn_seen;
  logic   last_item;

  logic signed [COORD_W:0] diff [AXES];
  logic [COORD_W-1:0] mcand  [AXES];
  logic [COORD_W-1:0] mplier [AXES];
  logic [COORD_W-1:0] acc    [AXES];
  logic [SQ_W:0]      sum01;
  logic [RAD_W-1:0]   radicand;
  logic [REM_W-1:0]   rem;
  logic [ROOT_W-1:0]  root;
  logic [CNT_W-1:0]   count;

  logic   out_valid;
  coord_t out_min [AXES];
  coord_t out_max [AXES];
  len_t   out_length;
  logic   out_empty;
  logic   out_warn;

  coord_t pt [AXES];
  logic   is_widen, is_move, is_draw, is_length;
  logic [COORD_W:0]   lane_sum [AXES];
  logic [REM_W+1:0]   rem_shift;
  logic [REM_W+1:0]   trial;
  logic               root_ge;
  logic [LEN_W:0]     len_add;
  logic               emit_go;

  assign pt[0] = items.point_x;
  assign pt[1] = items.point_y;
  assign pt[2] = items.point_z;

  assign is_move   = items.command inside {CMD_LINE_MOVE, CMD_TRI_MOVE, CMD_POLY_MOVE};
  assign is_draw   = items.command inside {CMD_LINE_DRAW, CMD_TRI_DRAW, CMD_POLY_DRAW};
  assign is_widen  = is_move || is_draw || (items.command == CMD_POINT_DRAW);
  assign is_length = is_draw || items.command inside {CMD_TRI_END, CMD_POLY_END};

  // one shift-add step of each axis multiplier
  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      lane_sum[a] = {1'b0, acc[a]} + (mplier[a][0] ? {1'b0, mcand[a]} : '0);
    end
  end

  // restoring square root, two radicand bits per step
  assign rem_shift = {rem, radicand[RAD_W-1 -: 2]};
  assign trial     = {2'b00, root, 2'b01};
  assign root_ge   = rem_shift >= trial;

  assign len_add = {1'b0, length_sum} + {{(LEN_W + 1 - ROOT_W){1'b0}}, root};
  assign emit_go = !out_valid || results.ready;

  assign items.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      length_sum   <= '0;
      segment_open <= 1'b0;
      warn_seen    <= 1'b0;
      last_item    <= 1'b0;
      count        <= '0;
      out_valid    <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        low[a]  <= COORD_POS_MAX;
        high[a] <= COORD_NEG_MAX;
        prev[a] <= '0;
      end
    end else begin
      // the emit state handles its own valid
      if (out_valid && results.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (items.valid) begin
            for (int a = 0; a < AXES; a++) begin
              if (is_widen && (pt[a] < low[a])) low[a] <= pt[a];
              if (is_widen && (pt[a] > high[a])) high[a] <= pt[a];
              diff[a] <= {pt[a][COORD_W-1], pt[a]} - {prev[a][COORD_W-1], prev[a]};
              prev[a] <= pt[a];
            end
            if (is_move) begin
              segment_open <= 1'b1;
            end else if (!is_draw && (is_widen || is_length)) begin
              segment_open <= 1'b0;
            end
            if (is_draw && !segment_open) warn_seen <= 1'b1;
            last_item <= items.list_end;
            if (is_length) begin
              state <= S_ABS;
            end else if (items.list_end) begin
              state <= S_EMIT;
            end
          end
        end
        S_ABS: begin
          for (int a = 0; a < AXES; a++) begin
            // magnitude of a coordinate difference always fits the coordinate width
            mcand[a]  <= diff[a][COORD_W] ? COORD_W'(-diff[a]) : diff[a][COORD_W-1:0];
            mplier[a] <= diff[a][COORD_W] ? COORD_W'(-diff[a]) : diff[a][COORD_W-1:0];
            acc[a]    <= '0;
          end
          count <= CNT_W'(COORD_W - 1);
          state <= S_MUL;
        end
        S_MUL: begin
          for (int a = 0; a < AXES; a++) begin
            acc[a]    <= lane_sum[a][COORD_W:1];
            mplier[a] <= {lane_sum[a][0], mplier[a][COORD_W-1:1]};
          end
          if (count == '0) begin
            state <= S_SUM1;
          end else begin
            count <= count - 1'b1;
          end
        end
        S_SUM1: begin
          sum01 <= {1'b0, acc[0], mplier[0]} + {1'b0, acc[1], mplier[1]};
          state <= S_SUM2;
        end
        S_SUM2: begin
          radicand <= {1'b0, sum01} + {2'b00, acc[2], mplier[2]};
          rem      <= '0;
          root     <= '0;
          count    <= CNT_W'(ROOT_W - 1);
          state    <= S_ROOT;
        end
        S_ROOT: begin
          rem      <= root_ge ? REM_W'(rem_shift - trial) : REM_W'(rem_shift);
          root     <= {root[ROOT_W-2:0], root_ge};
          radicand <= {radicand[RAD_W-3:0], 2'b00};
          if (count == '0) begin
            state <= S_ACCUM;
          end else begin
            count <= count - 1'b1;
          end
        end
        S_ACCUM: begin
          length_sum <= len_add[LEN_W] ? LEN_MAX : len_add[LEN_W-1:0];
          state      <= last_item ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid  <= 1'b1;
            out_length <= length_sum;
            out_empty  <= low[0] > high[0];
            out_warn   <= warn_seen;
            for (int a = 0; a < AXES; a++) begin
              out_min[a] <= low[a];
              out_max[a] <= high[a];
              low[a]     <= COORD_POS_MAX;
              high[a]    <= COORD_NEG_MAX;
              prev[a]    <= '0;
            end
            length_sum   <= '0;
            segment_open <= 1'b0;
            warn_seen    <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign results.valid             = out_valid;
  assign results.min_x             = out_min[0];
  assign results.min_y             = out_min[1];
  assign results.min_z             = out_min[2];
  assign results.max_x             = out_max[0];
  assign results.max_y             = out_max[1];
  assign results.max_z             = out_max[2];
  assign results.path_length       = out_length;
  assign results.bounds_empty      = out_empty;
  assign results.draw_without_move = out_warn;

endmodule

`default_nettype wire

### design/pbl_checker.sv
// port-level checks on the polyline bounds and length block
// depends on pbl_pkg; attached to the top level by the bind at the end
`default_nettype none

module pbl_checker (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic signed [pbl_pkg::COORD_W-1:0] min_x,
  input logic signed [pbl_pkg::COORD_W-1:0] min_y,
  input logic signed [pbl_pkg::COORD_W-1:0] min_z,
  input logic signed [pbl_pkg::COORD_W-1:0] max_x,
  input logic signed [pbl_pkg::COORD_W-1:0] max_y,
  input logic signed [pbl_pkg::COORD_W-1:0] max_z,
  input logic [pbl_pkg::LEN_W-1:0] path_length,
  input logic bounds_empty
);
  import pbl_pkg::*;

  // no result survives a reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result keeps its length
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(path_length))
    else $error("stalled result changed");

  // a widened box is ordered on every axis
  a_box_ordered: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bounds_empty |-> (min_x <= max_x) && (min_y <= max_y) && (min_z <= max_z))
    else $error("non-empty box with min above max");

  // an empty box still holds the reset extremes on the y and z axes
  a_empty_extremes: assert property (@(posedge clk) disable iff (rst)
    out_valid && bounds_empty |->
      (min_y == COORD_POS_MAX) && (max_y == COORD_NEG_MAX) &&
      (min_z == COORD_POS_MAX) && (max_z == COORD_NEG_MAX))
    else $error("empty box with widened bounds");

endmodule

bind polyline_bbox_and_length pbl_checker u_pbl_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (results.valid),
  .out_ready   (results.ready),
  .min_x       (results.min_x),
  .min_y       (results.min_y),
  .min_z       (results.min_z),
  .max_x       (results.max_x),
  .max_y       (results.max_y),
  .max_z       (results.max_z),
  .path_length (results.path_length),
  .bounds_empty(results.bounds_empty)
);

`default_nettype wire

### dv/tb.sv
// testbench for polyline_bbox_and_length: directed and random drawing command lists,
// with every list summary checked against a cycle-free model of bounds and path length
// depends on pbl_pkg, pbl_in_if, pbl_out_if and the block itself
`timescale 1ns / 100ps
`default_nettype none

module tb;
  import pbl_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 80;
  localparam int IDLE_PCT     = 19;
  localparam int CMD_CODES    = 2 ** CMD_W;

  typedef logic [AXES-1:0][COORD_W-1:0] point_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
    len_t   path_length;
    logic   bounds_empty;
    logic   draw_without_move;
  } bbox_summary_t;

  typedef struct {
    logic [CMD_W-1:0] command;
    coord_t           x;
    coord_t           y;
    coord_t           z;
  } draw_cmd_t;

  logic clk = 1'b0;
  logic rst;
  bit   quiet = 1'b0;
  int   mismatches = 0;
  int   reqs_taken = 0;
  int   lists_checked = 0;
  int   stall_cycles = 0;

  pbl_in_if  items_ch ();
  pbl_out_if results_ch ();

  polyline_bbox_and_length uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // running bounds, length and previous point of the list being received
  point_t        lo_pt;
  point_t        hi_pt;
  point_t        prev_pt;
  len_t          len_acc;
  logic          seg_open;
  logic          warned;
  bbox_summary_t expected_summaries[$];

  // floor of the distance from the previous point, Q20.16
  function automatic logic [35:0] segment_length(point_t pt);
    logic signed [COORD_W:0] diff;
    logic [RAD_W-1:0]        rad;
    logic [35:0]             root;
    logic [35:0]             trial;
    rad = '0;
    for (int a = 0; a < AXES; a++) begin
      diff = {pt[a][COORD_W-1], pt[a]} - {prev_pt[a][COORD_W-1], prev_pt[a]};
      if (diff < 0) diff = -diff;
      rad = rad + RAD_W'(diff) * RAD_W'(diff);
    end
    root = '0;
    for (int b = 34; b >= 0; b--) begin
      trial = root | (36'd1 << b);
      if (72'(trial) * 72'(trial) <= 72'(rad)) root = trial;
    end
    return root;
  endfunction

  task automatic clear_tracking();
    for (int a = 0; a < AXES; a++) begin
      lo_pt[a] = COORD_POS_MAX;
      hi_pt[a] = COORD_NEG_MAX;
    end
    prev_pt  = '0;
    len_acc  = '0;
    seg_open = 1'b0;
    warned   = 1'b0;
  endtask

  task automatic widen_bounds(point_t pt);
    for (int a = 0; a < AXES; a++) begin
      if ($signed(pt[a]) < $signed(lo_pt[a])) lo_pt[a] = pt[a];
      if ($signed(pt[a]) > $signed(hi_pt[a])) hi_pt[a] = pt[a];
    end
  endtask

  task automatic add_segment(point_t pt);
    logic [LEN_W:0] sum;
    sum = len_acc + segment_length(pt);
    len_acc = (sum > LEN_MAX) ? LEN_MAX : sum[LEN_W-1:0];
  endtask

  task automatic track_request(logic [CMD_W-1:0] cmd, point_t pt, logic last);
    bbox_summary_t s;
    case (cmd)
      CMD_POINT_DRAW: begin
        seg_open = 1'b0;
        widen_bounds(pt);
      end
      CMD_LINE_MOVE, CMD_TRI_MOVE, CMD_POLY_MOVE: begin
        seg_open = 1'b1;
        widen_bounds(pt);
      end
      CMD_LINE_DRAW, CMD_TRI_DRAW, CMD_POLY_DRAW: begin
        if (!seg_open) warned = 1'b1;
        widen_bounds(pt);
        add_segment(pt);
      end
      CMD_TRI_END, CMD_POLY_END: begin
        add_segment(pt);
        seg_open = 1'b0;
      end
      default: ;
    endcase
    prev_pt = pt;
    if (last) begin
      s.min_x             = lo_pt[0];
      s.min_y             = lo_pt[1];
      s.min_z             = lo_pt[2];
      s.max_x             = hi_pt[0];
      s.max_y             = hi_pt[1];
      s.max_z             = hi_pt[2];
      s.path_length       = len_acc;
      s.bounds_empty      = $signed(lo_pt[0]) > $signed(hi_pt[0]);
      s.draw_without_move = warned;
      expected_summaries.insert(expected_summaries.size(), s);
      clear_tracking();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_tracking();
    end else if (items_ch.valid && items_ch.ready) begin
      track_request(items_ch.command,
                    {items_ch.point_z, items_ch.point_y, items_ch.point_x},
                    items_ch.list_end);
      reqs_taken++;
    end
  end

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_result
    bbox_summary_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      if (expected_summaries.size() == 0) begin
        $display("%0t: summary arrived with no list pending", $time);
        mismatches++;
      end else begin
        want = expected_summaries.pop_front();
        check_field("min_x", want.min_x, results_ch.min_x);
        check_field("min_y", want.min_y, results_ch.min_y);
        check_field("min_z", want.min_z, results_ch.min_z);
        check_field("max_x", want.max_x, results_ch.max_x);
        check_field("max_y", want.max_y, results_ch.max_y);
        check_field("max_z", want.max_z, results_ch.max_z);
        check_field("path_length", want.path_length, results_ch.path_length);
        check_field("bounds_empty", want.bounds_empty, results_ch.bounds_empty);
        check_field("draw_without_move", want.draw_without_move,
                    results_ch.draw_without_move);
        lists_checked++;
      end
    end
  end

  always @(posedge clk) results_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);

  always @(posedge clk) begin
    if (rst || (items_ch.valid && items_ch.ready) ||
        (results_ch.valid && results_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: nothing moved on either channel for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // valid stays high on return so back-to-back requests need no extra edge
  task automatic send_item(logic [CMD_W-1:0] cmd, coord_t x, coord_t y, coord_t z,
                           logic last);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid    <= 1'b1;
    items_ch.command  <= cmd;
    items_ch.point_x  <= x;
    items_ch.point_y  <= y;
    items_ch.point_z  <= z;
    items_ch.list_end <= last;
    @(posedge clk);
    while (!items_ch.ready) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    coord_t c;
    case ($urandom_range(9))
      0, 1: c = coord_t'($urandom);
      2: begin
        case ($urandom_range(4))
          0:       c = COORD_POS_MAX;
          1:       c = COORD_NEG_MAX;
          2:       c = '0;
          3:       c = '1;
          default: c = coord_t'(1);
        endcase
      end
      default: c = coord_t'($urandom_range(32'h0080_0000)) - coord_t'(32'h0040_0000);
    endcase
    return c;
  endfunction

  function automatic draw_cmd_t rand_req(logic [CMD_W-1:0] cmd);
    draw_cmd_t r;
    r.command = cmd;
    r.x = rand_coord();
    r.y = rand_coord();
    r.z = rand_coord();
    return r;
  endfunction

  // mostly move/draw/end strokes, the rest arbitrary command noise
  task automatic run_random_lists(int n_items);
    draw_cmd_t lst[$];
    int        sent;
    int        kind;
    sent = 0;
    while (sent < n_items) begin
      lst.delete();
      if ($urandom_range(99) < 25) begin
        repeat ($urandom_range(1, 8))
          lst.insert(lst.size(), rand_req(CMD_W'($urandom_range(CMD_CODES - 1))));
      end else begin
        repeat ($urandom_range(1, 3)) begin
          kind = $urandom_range(2);
          if ($urandom_range(99) < 20) lst.insert(lst.size(), rand_req(CMD_POINT_DRAW));
          lst.insert(lst.size(), rand_req(CMD_W'(CMD_LINE_MOVE + kind)));
          repeat ($urandom_range(1, 5))
            lst.insert(lst.size(), rand_req(CMD_W'(CMD_LINE_DRAW + kind)));
          if (kind != 0 && $urandom_range(99) < 70)
            lst.insert(lst.size(), rand_req(kind == 1 ? CMD_TRI_END : CMD_POLY_END));
        end
      end
      foreach (lst[i])
        send_item(lst[i].command, lst[i].x, lst[i].y, lst[i].z, i == lst.size() - 1);
      sent += lst.size();
    end
  endtask

  task automatic test_empty_bounds();
    send_item(CMD_OTHER, coord_t'(1), coord_t'(2), coord_t'(3), 1'b1);
  endtask

  // 3-4-5 triangle from the origin, bounds stay empty
  task automatic test_lone_end();
    send_item(CMD_TRI_END, coord_t'(3 << FRAC_W), coord_t'(4 << FRAC_W), '0, 1'b1);
  endtask

  task automatic test_draw_without_move();
    send_item(CMD_LINE_DRAW, COORD_POS_MAX, COORD_NEG_MAX, '0, 1'b1);
    send_item(CMD_POINT_DRAW, '0, '0, '0, 1'b0);
    send_item(CMD_POLY_DRAW, coord_t'(1), coord_t'(1), coord_t'(1), 1'b1);
  endtask

  task automatic test_extreme_coords();
    send_item(CMD_POLY_MOVE, COORD_NEG_MAX, COORD_NEG_MAX, COORD_NEG_MAX, 1'b0);
    send_item(CMD_POLY_DRAW, COORD_POS_MAX, COORD_POS_MAX, COORD_POS_MAX, 1'b0);
    send_item(CMD_POLY_DRAW, COORD_NEG_MAX, COORD_POS_MAX, COORD_NEG_MAX, 1'b0);
    send_item(CMD_POLY_END, COORD_POS_MAX, COORD_NEG_MAX, COORD_POS_MAX, 1'b1);
  endtask

  // one list through every code, including the unused ones
  task automatic test_every_command();
    draw_cmd_t r;
    for (int c = 0; c < CMD_CODES; c++) begin
      r = rand_req(CMD_W'(c));
      send_item(r.command, r.x, r.y, r.z, c == CMD_CODES - 1);
    end
  endtask

  task automatic test_random_lists();
    run_random_lists(650);
  endtask

  task automatic test_unthrottled_burst();
    quiet = 1'b1;
    run_random_lists(150);
    quiet = 1'b0;
  endtask

  initial begin
    rst                 <= 1'b1;
    items_ch.valid      <= 1'b0;
    items_ch.command    <= CMD_OTHER;
    items_ch.point_x    <= '0;
    items_ch.point_y    <= '0;
    items_ch.point_z    <= '0;
    items_ch.list_end   <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_empty_bounds();
    test_lone_end();
    test_draw_without_move();
    test_extreme_coords();
    test_every_command();
    test_random_lists();
    test_unthrottled_burst();

    items_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_summaries.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    // length saturation needs tens of thousands of maximal segments, out of reach here
    $display("run covered %0d requests and %0d list summaries, %0d mismatches",
             reqs_taken, lists_checked, mismatches);
    $display("lists mixed strokes, command noise, all sixteen codes and full-range points");
    if (mismatches == 0 && expected_summaries.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
